// File: rtl/vsd_pkg.sv
// Package for the varint stream decoder.
// Field widths, octet bit positions and status codes. No dependencies.
package vsd_pkg;

    localparam int OCTET_W  = 8;
    localparam int VALUE_W  = 64;
    localparam int COUNT_W  = 4;
    localparam int STATUS_W = 2;
    localparam int GROUP_W  = 7;

    localparam int MORE_BIT = 7;
    localparam int SIGN_BIT = 6;

    localparam logic [COUNT_W-1:0] MAX_OCTETS = 4'd10;

    localparam logic [OCTET_W-1:0] LEAD_UNSIGNED_OK = 8'h81;
    localparam logic [OCTET_W-1:0] LEAD_SIGNED_POS  = 8'h80;
    localparam logic [OCTET_W-1:0] LEAD_SIGNED_NEG  = 8'hff;

    // m_tdata: decoded_value, octet_count, zero pad to whole bytes
    localparam int M_TDATA_W = ((VALUE_W + COUNT_W + 7) / 8) * 8;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_TOO_LONG  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_MALFORMED = 2'd2;

    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [COUNT_W-1:0]  count;
        logic [STATUS_W-1:0] status;
    } result_t;

endpackage

// File: rtl/varint_stream_decoder.sv
// Varint stream decoder: big-endian 7-bit groups, unsigned or signed mode.
// A finished result goes to the output register, or to the skid slot if m_tready stalls one.
// Throughput: one octet beat per cycle while the skid slot is empty; a two-entry output
// (register + skid) keeps s_tready high while one result waits on a stalled m_tready.
// Reset (rst_n, async, active low): decoder restarts, no result pending.
// Depends on vsd_pkg.
module varint_stream_decoder
    import vsd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [OCTET_W-1:0]    s_tdata,   // [7:0] octet
    input  logic                  s_tuser,   // [0] func (0 unsigned, 1 signed)

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [63:0] decoded_value, [67:64] octet_count,
                                             // [71:68] zero
    output logic [STATUS_W-1:0]   m_tuser    // [1:0] status
);

    // decoder state
    logic [VALUE_W-1:0] acc_reg;
    logic [COUNT_W-1:0] seen_reg;
    logic [OCTET_W-1:0] lead_reg;
    logic               mode_reg;

    // output register and skid slot
    result_t out_reg;
    logic    out_valid_reg;
    result_t skid_reg;
    logic    skid_valid_reg;

    logic               s_fire;
    logic               m_fire;
    logic               first;
    logic               mode;
    logic [OCTET_W-1:0] lead;
    logic [VALUE_W-1:0] acc_base;
    logic [VALUE_W-1:0] acc_next;
    logic [COUNT_W-1:0] count;
    logic               more;
    logic               has_result;
    logic               bad_lead;
    result_t            res;

    assign s_tready = !skid_valid_reg;
    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = out_valid_reg && m_tready;

    // first octet of an integer samples mode and leading octet
    assign first = (seen_reg == '0);
    assign mode  = first ? s_tuser : mode_reg;
    assign lead  = first ? s_tdata : lead_reg;

    always_comb
    begin
        if (first)
        begin
            acc_base = (s_tuser && s_tdata[SIGN_BIT]) ? '1 : '0;
        end
        else
        begin
            acc_base = acc_reg;
        end
    end

    // shift in one group; bits above 63 drop off
    assign acc_next = {acc_base[VALUE_W-GROUP_W-1:0], s_tdata[GROUP_W-1:0]};
    assign count    = seen_reg + 1'b1;
    assign more     = s_tdata[MORE_BIT];

    assign has_result = !more || (count == MAX_OCTETS);

    assign bad_lead = mode ? ((lead != LEAD_SIGNED_POS) && (lead != LEAD_SIGNED_NEG))
                           : (lead != LEAD_UNSIGNED_OK);

    always_comb
    begin
        res.value  = acc_next;
        res.count  = count;
        res.status = STATUS_OK;
        if (more)
        begin
            // tenth octet still wants more
            res.value  = '0;
            res.count  = MAX_OCTETS;
            res.status = STATUS_TOO_LONG;
        end
        else if ((count == MAX_OCTETS) && bad_lead)
        begin
            res.value  = '0;
            res.status = STATUS_MALFORMED;
        end
    end

    // decoder state: only the octet count is control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
        end
        else if (s_fire)
        begin
            seen_reg <= has_result ? '0 : count;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            acc_reg  <= acc_next;
            lead_reg <= lead;
            mode_reg <= mode;
        end
    end

    // output register with skid slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (m_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (s_fire && has_result)
        begin
            if (out_valid_reg && !m_tready)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (m_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (m_fire)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (s_fire && has_result)
        begin
            if (out_valid_reg && !m_tready)
            begin
                skid_reg <= res;
            end
            else
            begin
                out_reg <= res;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-VALUE_W-COUNT_W){1'b0}}, out_reg.count, out_reg.value};
    assign m_tuser  = out_reg.status;

endmodule
